/* hw/rtl/binary_trie_ordered_key_store_macros.svh */
// Assertion macros used by the ordered key store datapath.
`ifndef BINARY_TRIE_ORDERED_KEY_STORE_MACROS_SVH
`define BINARY_TRIE_ORDERED_KEY_STORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every rising clock edge out of reset.
`define BTOKS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("btoks check failed");
// Implication checked in the same cycle.
`define BTOKS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("btoks check failed");
`else
`define BTOKS_ASSERT(lbl, clk, rst, prop)
`define BTOKS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/btoks_pkg.sv */
// Shared types, codes and defaults for the ordered key store.
package btoks_pkg;

  localparam int KEY_BITS_DEF   = 32;
  localparam int NODE_SLOTS_DEF = 4096;
  localparam int VALUE_BITS_DEF = 32;

  // Request codes
  localparam logic [2:0] REQ_INS  = 3'd0;
  localparam logic [2:0] REQ_LOOK = 3'd1;
  localparam logic [2:0] REQ_GE   = 3'd2;
  localparam logic [2:0] REQ_LE   = 3'd3;
  localparam logic [2:0] REQ_REM  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WALK,
    OP_WALK_EV,
    OP_LEAF_EV,
    OP_FULL,
    OP_FOUND,
    OP_POP,
    OP_INS_FIN,
    OP_RM_START,
    OP_RM_PAR,
    OP_RM_CH,
    OP_NB_INIT,
    OP_NB_PCH,
    OP_NB_EV,
    OP_DS_EV,
    OP_DS_LF_EV,
    OP_EMIT
  } dp_op_t;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic [2:0] req;
    logic       at_leaf;
    logic       link_ok;
    logic       leaf_ok;
    logic       room;
    logic       exact;
    logic       prune_go;
    logic       nb_hit;
    logic       ds_ok;
    logic       dd_zero;
    logic       out_busy;
  } dp_stat_t;

endpackage

/* hw/rtl/btoks_ctrl.sv */
// Sequencing state machine of the ordered key store.
module btoks_ctrl import btoks_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_WALK     = 18'h00002,
    S_WALK_EV  = 18'h00004,
    S_LEAF     = 18'h00008,
    S_DISP     = 18'h00010,
    S_ALLOC    = 18'h00020,
    S_POP      = 18'h00040,
    S_RM_START = 18'h00080,
    S_RM_RD    = 18'h00100,
    S_RM_PAR   = 18'h00200,
    S_RM_CH    = 18'h00400,
    S_NB_PRD   = 18'h00800,
    S_NB_PCH   = 18'h01000,
    S_NB_EV    = 18'h02000,
    S_DS       = 18'h04000,
    S_DS_EV    = 18'h08000,
    S_DS_LF    = 18'h10000,
    S_EMIT     = 18'h20000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the operation and the next state
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.at_leaf) begin
          state_next = S_LEAF;
        end else begin
          op         = OP_WALK;
          state_next = S_WALK_EV;
        end
      end
      S_WALK_EV: begin
        op         = OP_WALK_EV;
        state_next = stat.link_ok ? S_WALK : S_DISP;
      end
      S_LEAF: begin
        op         = OP_LEAF_EV;
        state_next = S_DISP;
      end
      S_DISP: begin
        state_next = S_EMIT;
        case (stat.req)
          REQ_INS: begin
            if (!stat.room) begin
              op = OP_FULL;
            end else begin
              state_next = S_ALLOC;
            end
          end
          REQ_LOOK, REQ_REM: begin
            if (stat.exact) begin
              op = OP_FOUND;
              if (stat.req == REQ_REM) state_next = S_RM_START;
            end
          end
          REQ_GE, REQ_LE: begin
            if (stat.exact) begin
              op = OP_FOUND;
            end else begin
              op         = OP_NB_INIT;
              state_next = S_NB_PRD;
            end
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_ALLOC: begin
        if (stat.at_leaf) begin
          op         = OP_INS_FIN;
          state_next = S_EMIT;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        op         = OP_POP;
        state_next = S_ALLOC;
      end
      S_RM_START: begin
        op         = OP_RM_START;
        state_next = S_RM_PAR;
      end
      S_RM_RD: state_next = S_RM_PAR;
      S_RM_PAR: begin
        op         = OP_RM_PAR;
        state_next = S_RM_CH;
      end
      S_RM_CH: begin
        op         = OP_RM_CH;
        state_next = stat.prune_go ? S_RM_RD : S_EMIT;
      end
      S_NB_PRD: state_next = S_NB_PCH;
      S_NB_PCH: begin
        op         = OP_NB_PCH;
        state_next = S_NB_EV;
      end
      S_NB_EV: begin
        op = OP_NB_EV;
        if (stat.nb_hit) begin
          state_next = S_DS;
        end else begin
          state_next = stat.dd_zero ? S_EMIT : S_NB_PRD;
        end
      end
      S_DS: state_next = stat.at_leaf ? S_DS_LF : S_DS_EV;
      S_DS_EV: begin
        op = OP_DS_EV;
        if (stat.ds_ok) begin
          state_next = S_DS;
        end else begin
          state_next = stat.dd_zero ? S_EMIT : S_NB_PRD;
        end
      end
      S_DS_LF: begin
        op = OP_DS_LF_EV;
        if (stat.leaf_ok || stat.dd_zero) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_NB_PRD;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/btoks_dp.sv */
// Node memories, counters and result registers of the ordered key store.
`include "binary_trie_ordered_key_store_macros.svh"
module btoks_dp import btoks_pkg::*; #(
  parameter int KB = KEY_BITS_DEF,
  parameter int NS = NODE_SLOTS_DEF,
  parameter int VB = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_op_t      op,
  output dp_stat_t    stat,
  input  logic [2:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] found_key,
  output logic [31:0] found_value,
  output logic [12:0] node_count,
  output logic [12:0] key_count
);

  localparam int LB = $clog2(NS + 1);
  localparam int IW = $clog2(NS);
  localparam int DW = $clog2(KB + 1);
  localparam int PW = LB + 1;
  localparam int RW = LB + 1;
  localparam logic [LB-1:0] ROOT = LB'(NS);
  localparam logic [KB-1:0] TOP  = {1'b1, {(KB - 1){1'b0}}};
  localparam logic [KB-1:0] ONES = '1;

  // Request and walk registers
  logic [2:0]      req;
  logic [KB-1:0]   k, acc;
  logic [VB-1:0]   v, lv;
  logic [DW-1:0]   d, dd;
  logic [LB-1:0]   cur, par;
  logic            pb, exact, alloc_any;
  logic [2*LB-1:0] chd, root_ch;
  logic [LB-1:0]   used, keys, hw;
  logic [1:0]      rs_status;
  logic [KB-1:0]   rs_fk;
  logic [VB-1:0]   rs_fv;
  logic [1:0]      o_status;
  logic [KB-1:0]   o_fk;
  logic [VB-1:0]   o_fv;
  logic [LB-1:0]   o_used, o_keys;

  // Memories
  logic [2*LB-1:0] child_mem [NS];
  logic [PW-1:0]   par_mem   [NS];
  logic [VB:0]     leaf_mem  [NS];
  logic [IW-1:0]   free_mem  [NS];
  logic [LB-1:0]   path_mem  [KB+1];

  logic [2*LB-1:0] ch_q, ch_wd, root_wd;
  logic [LB-1:0]   ch_ra;
  logic [IW-1:0]   ch_wa, pa_ra, pa_wa, lf_ra, lf_wa, fr_ra, fr_wa, fr_wd;
  logic            ch_we, pa_we, lf_we, fr_we, pt_we, root_we, rd_root;
  logic [PW-1:0]   par_q, pa_wd;
  logic [VB:0]     lf_q, lf_wd;
  logic [IW-1:0]   fr_q;
  logic [LB-1:0]   pt_q;

  // Derived values
  logic [2*LB-1:0] ch_now, chd_set, chn;
  logic [LB-1:0]   c0, c1, c_walk, c_dir, c_pref, c_oth, new_link, pop_t, push_t;
  logic [IW-1:0]   pop_pos, push_pos, new_n;
  logic            bd, bdd, dir;

  function automatic logic kbit(input logic [KB-1:0] kk, input logic [DW-1:0] dx);
    logic [KB-1:0] t;
    t    = kk << dx;
    kbit = t[KB-1];
  endfunction

  assign ch_now   = rd_root ? root_ch : ch_q;
  assign c0       = ch_now[LB-1:0];
  assign c1       = ch_now[2*LB-1:LB];
  assign bd       = kbit(k, d);
  assign bdd      = kbit(k, dd);
  assign dir      = (req == REQ_GE);
  assign c_walk   = bd ? c1 : c0;
  assign c_dir    = dir ? c1 : c0;
  assign c_pref   = dir ? c0 : c1;
  assign c_oth    = dir ? c1 : c0;
  assign pop_t    = ROOT - used - LB'(1);
  assign push_t   = ROOT - used;
  assign pop_pos  = pop_t[IW-1:0];
  assign push_pos = push_t[IW-1:0];
  // Stack slots not yet reached by the high-water mark were never pushed, so the slot's own position is the node
  assign new_n    = (used >= hw) ? pop_pos : fr_q;
  assign new_link = LB'(new_n) + LB'(1);
  assign chd_set  = bd ? {new_link, chd[LB-1:0]} : {chd[2*LB-1:LB], new_link};
  assign chn      = pb ? {LB'(0), ch_now[LB-1:0]} : {ch_now[2*LB-1:LB], LB'(0)};

  // Status back to the controller
  always_comb begin
    stat.req      = req;
    stat.at_leaf  = (d == DW'(KB));
    stat.link_ok  = (c_walk != '0);
    stat.leaf_ok  = lf_q[VB];
    stat.room     = (RW'(KB) - RW'(d)) <= (RW'(NS) - RW'(used));
    stat.exact    = exact;
    stat.prune_go = (chn == '0) && (par != ROOT);
    stat.nb_hit   = (bdd != dir) && (c_dir != '0);
    stat.ds_ok    = (c_pref != '0) || (c_oth != '0);
    stat.dd_zero  = (dd == '0);
    stat.out_busy = out_valid && out_stall;
  end

  // Memory port control
  always_comb begin
    ch_ra   = cur;
    ch_we   = 1'b0;
    ch_wa   = cur[IW-1:0];
    ch_wd   = chd;
    root_we = 1'b0;
    root_wd = chd_set;
    pa_ra   = cur[IW-1:0];
    pa_we   = 1'b0;
    pa_wa   = new_n;
    pa_wd   = {cur, bd};
    lf_ra   = cur[IW-1:0];
    lf_we   = 1'b0;
    lf_wa   = cur[IW-1:0];
    lf_wd   = '0;
    fr_ra   = pop_pos;
    fr_we   = 1'b0;
    fr_wa   = push_pos;
    fr_wd   = cur[IW-1:0];
    pt_we   = 1'b0;
    case (op)
      OP_WALK: pt_we = 1'b1;
      OP_POP: begin
        ch_we   = (cur != ROOT);
        ch_wd   = chd_set;
        root_we = (cur == ROOT);
        pa_we   = 1'b1;
        lf_we   = 1'b1;
        lf_wa   = new_n;
      end
      OP_INS_FIN: begin
        lf_we = 1'b1;
        lf_wd = {1'b1, v};
        ch_we = alloc_any;
        ch_wd = '0;
      end
      OP_RM_START: begin
        lf_we = 1'b1;
        lf_wd = {1'b0, lv};
      end
      OP_RM_PAR: begin
        ch_ra = par_q[PW-1:1];
        fr_we = 1'b1;
      end
      OP_RM_CH: begin
        ch_we   = (par != ROOT);
        ch_wa   = par[IW-1:0];
        ch_wd   = chn;
        root_we = (par == ROOT);
        root_wd = chn;
      end
      OP_NB_PCH: ch_ra = pt_q;
      default: ch_ra = cur;
    endcase
  end

  // Node memories with registered reads
  always_ff @(posedge clk) begin
    if (ch_we) child_mem[ch_wa] <= ch_wd;
    ch_q    <= child_mem[ch_ra[IW-1:0]];
    rd_root <= (ch_ra == ROOT);
  end

  always_ff @(posedge clk) begin
    if (pa_we) par_mem[pa_wa] <= pa_wd;
    par_q <= par_mem[pa_ra];
  end

  always_ff @(posedge clk) begin
    if (lf_we) leaf_mem[lf_wa] <= lf_wd;
    lf_q <= leaf_mem[lf_ra];
  end

  always_ff @(posedge clk) begin
    if (fr_we) free_mem[fr_wa] <= fr_wd;
    fr_q <= free_mem[fr_ra];
  end

  always_ff @(posedge clk) begin
    if (pt_we) path_mem[d] <= cur;
    pt_q <= path_mem[dd];
  end

  // Control registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      used      <= '0;
      keys      <= '0;
      hw        <= '0;
      root_ch   <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (root_we) root_ch <= root_wd;
      case (op)
        OP_POP: begin
          used <= used + LB'(1);
          if (used >= hw) hw <= used + LB'(1);
        end
        OP_INS_FIN: if (!exact) keys <= keys + LB'(1);
        OP_RM_START: keys <= keys - LB'(1);
        OP_RM_PAR: used <= used - LB'(1);
        OP_EMIT: out_valid <= 1'b1;
        default: used <= used;
      endcase
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        req       <= req_type;
        k         <= KB'(key);
        v         <= VB'(value);
        d         <= '0;
        cur       <= ROOT;
        rs_status <= ST_MISS;
        rs_fk     <= '0;
        rs_fv     <= '0;
        exact     <= 1'b0;
        alloc_any <= 1'b0;
      end
      OP_WALK_EV: begin
        chd <= ch_now;
        if (c_walk != '0) begin
          cur <= c_walk - LB'(1);
          d   <= d + DW'(1);
        end
      end
      OP_LEAF_EV: begin
        exact <= lf_q[VB];
        lv    <= lf_q[VB-1:0];
      end
      OP_FULL: rs_status <= ST_FULL;
      OP_FOUND: begin
        rs_status <= ST_DONE;
        rs_fk     <= k;
        rs_fv     <= lv;
      end
      OP_POP: begin
        chd       <= '0;
        cur       <= LB'(new_n);
        d         <= d + DW'(1);
        alloc_any <= 1'b1;
      end
      OP_INS_FIN: begin
        rs_status <= ST_DONE;
        rs_fk     <= k;
        rs_fv     <= v;
      end
      OP_RM_PAR: begin
        par <= par_q[PW-1:1];
        pb  <= par_q[0];
      end
      OP_RM_CH: cur <= par;
      OP_NB_INIT: dd <= stat.at_leaf ? DW'(KB - 1) : d;
      OP_NB_EV: begin
        if (stat.nb_hit) begin
          acc <= (k & ~(ONES >> dd)) | (dir ? (TOP >> dd) : '0);
          cur <= c_dir - LB'(1);
          d   <= dd + DW'(1);
        end else if (dd != '0) begin
          dd <= dd - DW'(1);
        end
      end
      OP_DS_EV: begin
        if (c_pref != '0) begin
          cur <= c_pref - LB'(1);
          acc <= acc | (!dir ? (TOP >> d) : '0);
          d   <= d + DW'(1);
        end else if (c_oth != '0) begin
          cur <= c_oth - LB'(1);
          acc <= acc | (dir ? (TOP >> d) : '0);
          d   <= d + DW'(1);
        end else if (dd != '0) begin
          dd <= dd - DW'(1);
        end
      end
      OP_DS_LF_EV: begin
        if (lf_q[VB]) begin
          rs_status <= ST_DONE;
          rs_fk     <= acc;
          rs_fv     <= lf_q[VB-1:0];
        end else if (dd != '0) begin
          dd <= dd - DW'(1);
        end
      end
      OP_EMIT: begin
        o_status <= rs_status;
        o_fk     <= rs_fk;
        o_fv     <= rs_fv;
        o_used   <= used;
        o_keys   <= keys;
      end
      default: cur <= cur;
    endcase
  end

  assign status      = o_status;
  assign found_key   = 32'(o_fk);
  assign found_value = 32'(o_fv);
  assign node_count  = 13'(o_used);
  assign key_count   = 13'(o_keys);

  `BTOKS_ASSERT(a_keys_le_nodes, clk, rst, keys <= used)
  `BTOKS_ASSERT(a_mark_covers_used, clk, rst, used <= hw)
  `BTOKS_ASSERT_IMP(a_pop_has_room, clk, rst, op == OP_POP, used < ROOT)
  `BTOKS_ASSERT_IMP(a_push_has_node, clk, rst, op == OP_RM_PAR, used != '0)

endmodule

/* hw/rtl/binary_trie_ordered_key_store.sv */
// Top level of the ordered key store: a fixed-depth binary trie in node memory.
//
// Request channel (in_valid / in_stall): req_type, key, value. A request is
// taken when in_valid is high and in_stall low; the block takes one request
// at a time and holds in_stall high until that request's result is loaded.
// Result channel (out_valid / out_stall): status, found_key, found_value,
// node_count, key_count; one result per request, held while out_stall is high.
// The result register lets the next request start while a result still waits.
// The key walk reads the child-link memory once per trie level (states
// WALK and WALK_EV). An insert adds ALLOC and POP per new node, a remove
// adds RM_PAR, RM_CH and RM_RD per freed node, and a nearest search backs
// over levels in NB_PRD, NB_PCH and NB_EV and descends in DS and DS_EV.
// All of this is bound by the single read port of the child-link memory.
// Reset clears the node and key counts and the root links; the node memories
// need no clearing, and the free list is served by a high-water mark.
module binary_trie_ordered_key_store import btoks_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int NODE_SLOTS = NODE_SLOTS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] found_key,
  output logic [31:0] found_value,
  output logic [12:0] node_count,
  output logic [12:0] key_count
);

  dp_op_t   op;
  dp_stat_t stat;

  // Sequence each request
  btoks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  // Hold the trie and produce results
  btoks_dp #(
    .KB (KEY_BITS),
    .NS (NODE_SLOTS),
    .VB (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stat        (stat),
    .req_type    (req_type),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_key   (found_key),
    .found_value (found_value),
    .node_count  (node_count),
    .key_count   (key_count)
  );

endmodule
